>>> rtl/interval_overlap_intersect_core_assert.svh
// Assertion macros for the interval overlap core.
// Used by the top level only; no other dependencies.
`ifndef INTERVAL_OVERLAP_INTERSECT_CORE_ASSERT_SVH
`define INTERVAL_OVERLAP_INTERSECT_CORE_ASSERT_SVH
// condition implies consequence in the same cycle
`define IOI_ASSERT_IMPL(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
// condition implies consequence in the next cycle
`define IOI_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`endif

>>> rtl/ioi_pkg.sv
// Shared types and constants for the interval overlap core.
// No dependencies.
package ioi_pkg;
   localparam int TABLE_DEPTH_DEF = 64;
   localparam int COORD_WIDTH_DEF = 31;
   localparam int TAG_WIDTH = 16;
   localparam int IDX_WIDTH = 6;

   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_LOAD  = 2'd1;
   localparam logic [1:0] CMD_QUERY = 2'd2;

   localparam logic [1:0] ST_MATCH  = 2'd0;
   localparam logic [1:0] ST_NONE   = 2'd1;
   localparam logic [1:0] ST_ACCEPT = 2'd2;
   localparam logic [1:0] ST_FULL   = 2'd3;

   localparam logic [1:0] REL_LEFT  = 2'd0;
   localparam logic [1:0] REL_IN    = 2'd1;
   localparam logic [1:0] REL_RIGHT = 2'd2;
   localparam logic [1:0] REL_COVER = 2'd3;

   localparam logic [1:0] CSR_CLIP    = 2'd0;
   localparam logic [1:0] CSR_CONTAIN = 2'd1;
   localparam logic [1:0] CSR_COVER   = 2'd2;

   // datapath operation selected by the controller
   localparam logic [2:0] OP_NONE   = 3'd0;
   localparam logic [2:0] OP_LATCH  = 3'd1; // capture request, start search
   localparam logic [2:0] OP_READ   = 3'd2; // issue read at probe index
   localparam logic [2:0] OP_SEARCH = 3'd3; // evaluate binary search probe
   localparam logic [2:0] OP_LWALK  = 3'd4; // evaluate left walk entry
   localparam logic [2:0] OP_RWALK  = 3'd5; // evaluate right walk entry

   typedef struct packed {
      logic [2:0] op;
      logic       emit_simple; // send clear/load/none response
   } ctl_type;

   typedef struct packed {
      logic search_done; // search ended (hit or empty range)
      logic hit;
      logic walk_stop;   // walk entry outside range or not overlapping
      logic any_sent;
   } sts_type;
endpackage

>>> rtl/interval_overlap_intersect_core.sv
// Top level of the interval overlap core: controller, datapath, CSRs.
// Depends on ioi_pkg, ioi_ctrl, ioi_dpath and the assertion header.
//
//  channel | handshake          | contents
//  req     | start / busy       | command, interval, tag
//  rsp     | rsp_valid strobe   | status, index, interval, relation, tag, last
//  csr     | csr_valid/ready    | register index, write data
//
// Clear and load are taken while busy stays low and answered in the next cycle.
// A query is latched, then each search probe is a memory read then a
// compare (about log2 of the table size probes); after a hit the walk
// reads and checks neighbors left, then right, until one stops it, and a
// final state finishes; an empty search range goes straight to that state.
// Reset is synchronous; the table contents are undefined until loaded.
// Responses are strobed once and cannot be stalled.
`include "interval_overlap_intersect_core_assert.svh"
module interval_overlap_intersect_core #(
   parameter int TABLE_DEPTH = ioi_pkg::TABLE_DEPTH_DEF,
   parameter int COORD_WIDTH = ioi_pkg::COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_command,
   input  logic [COORD_WIDTH-1:0]        req_interval_start,
   input  logic [COORD_WIDTH-1:0]        req_interval_stop,
   input  logic [ioi_pkg::TAG_WIDTH-1:0] req_entry_tag,
   output logic                          rsp_valid,
   output logic [1:0]                    rsp_status,
   output logic [ioi_pkg::IDX_WIDTH-1:0] rsp_entry_index,
   output logic [COORD_WIDTH-1:0]        rsp_result_start,
   output logic [COORD_WIDTH-1:0]        rsp_result_stop,
   output logic [1:0]                    rsp_relation,
   output logic [ioi_pkg::TAG_WIDTH-1:0] rsp_result_tag,
   output logic                          rsp_last,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [1:0]                    csr_index,
   input  logic                          csr_data
);
   import ioi_pkg::*;

   ctl_type ctl;
   sts_type sts;
   logic clip_ff, contain_ff, cover_ff;
   logic clear_req;

   // configuration registers, always ready
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         clip_ff <= 1'b0; contain_ff <= 1'b0; cover_ff <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_CLIP:    clip_ff <= csr_data;
            CSR_CONTAIN: contain_ff <= csr_data;
            CSR_COVER:   cover_ff <= csr_data;
            default: ;
         endcase
      end
   end

   ioi_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .req_command(req_command),
      .sts(sts), .busy(busy), .ctl(ctl)
   );

   ioi_dpath #(.TABLE_DEPTH(TABLE_DEPTH), .COORD_WIDTH(COORD_WIDTH)) u_dpath (
      .clock(clock), .reset(reset), .ctl(ctl), .sts(sts),
      .req_command(req_command), .req_interval_start(req_interval_start),
      .req_interval_stop(req_interval_stop), .req_entry_tag(req_entry_tag),
      .csr_clip(clip_ff), .csr_contain(contain_ff), .csr_cover(cover_ff),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_entry_index(rsp_entry_index), .rsp_result_start(rsp_result_start),
      .rsp_result_stop(rsp_result_stop), .rsp_relation(rsp_relation),
      .rsp_result_tag(rsp_result_tag), .rsp_last(rsp_last)
   );

   assign clear_req = start && !busy && (req_command == CMD_CLEAR);

   // a clear request is answered in the next cycle
   `IOI_ASSERT_NEXT(a_simple_rsp, clock, reset, clear_req, rsp_valid && rsp_last)
   // non-match responses carry a zero relation
   `IOI_ASSERT_IMPL(a_match_fields, clock, reset, rsp_valid && (rsp_status != ST_MATCH), rsp_relation == REL_LEFT)
endmodule

>>> rtl/ioi_ctrl.sv
// Controller state machine for the interval overlap core.
// Depends on ioi_pkg.
module ioi_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [1:0]        req_command,
   input  ioi_pkg::sts_type  sts,
   output logic              busy,
   output ioi_pkg::ctl_type  ctl
);
   import ioi_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SRD   = 3'd1;
   localparam logic [2:0] S_SEV   = 3'd2;
   localparam logic [2:0] S_LRD   = 3'd3;
   localparam logic [2:0] S_LEV   = 3'd4;
   localparam logic [2:0] S_RRD   = 3'd5;
   localparam logic [2:0] S_REV   = 3'd6;
   localparam logic [2:0] S_DONE  = 3'd7;

   logic [2:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   assign busy = (state_ff != S_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      ctl.op = OP_NONE;
      ctl.emit_simple = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               ctl.op = OP_LATCH;
               // an empty search range goes straight to the no-match answer
               if (req_command == CMD_QUERY) state_in = sts.search_done ? S_DONE : S_SRD;
               else if ((req_command == CMD_CLEAR) || (req_command == CMD_LOAD))
                  ctl.emit_simple = 1'b1;
            end
         end
         S_SRD: begin
            ctl.op = OP_READ;
            state_in = S_SEV;
         end
         S_SEV: begin
            ctl.op = OP_SEARCH;
            if (sts.search_done) state_in = sts.hit ? S_LRD : S_DONE;
            else state_in = S_SRD;
         end
         S_LRD: begin
            ctl.op = OP_READ;
            state_in = S_LEV;
         end
         S_LEV: begin
            ctl.op = OP_LWALK;
            state_in = sts.walk_stop ? S_RRD : S_LRD;
         end
         S_RRD: begin
            ctl.op = OP_READ;
            state_in = S_REV;
         end
         S_REV: begin
            ctl.op = OP_RWALK;
            state_in = sts.walk_stop ? S_DONE : S_RRD;
         end
         S_DONE: begin
            ctl.emit_simple = !sts.any_sent;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule

>>> rtl/ioi_dpath.sv
// Datapath of the interval overlap core: table memory, search and walk
// registers, clip logic and response registers. Depends on ioi_pkg.
module ioi_dpath #(
   parameter int TABLE_DEPTH = ioi_pkg::TABLE_DEPTH_DEF,
   parameter int COORD_WIDTH = ioi_pkg::COORD_WIDTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  ioi_pkg::ctl_type            ctl,
   output ioi_pkg::sts_type            sts,
   input  logic [1:0]                  req_command,
   input  logic [COORD_WIDTH-1:0]      req_interval_start,
   input  logic [COORD_WIDTH-1:0]      req_interval_stop,
   input  logic [ioi_pkg::TAG_WIDTH-1:0] req_entry_tag,
   input  logic                        csr_clip,
   input  logic                        csr_contain,
   input  logic                        csr_cover,
   output logic                        rsp_valid,
   output logic [1:0]                  rsp_status,
   output logic [ioi_pkg::IDX_WIDTH-1:0] rsp_entry_index,
   output logic [COORD_WIDTH-1:0]      rsp_result_start,
   output logic [COORD_WIDTH-1:0]      rsp_result_stop,
   output logic [1:0]                  rsp_relation,
   output logic [ioi_pkg::TAG_WIDTH-1:0] rsp_result_tag,
   output logic                        rsp_last
);
   import ioi_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int MW = 2 * COORD_WIDTH + TAG_WIDTH;
   localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

   // table memory
   logic [MW-1:0] mem [TABLE_DEPTH];
   logic [MW-1:0] rd_ff;

   logic [CW-1:0] count_ff, count_in, lowb_ff, lowb_in;
   logic [CW:0]   lo_ff, lo_in, hi_ff, hi_in;   // signed range bounds
   logic [CW:0]   idx_ff, idx_in, hit_ff, hit_in;
   logic [COORD_WIDTH-1:0] qs_ff, qe_ff;
   logic          sent_ff, sent_in;

   logic [CW:0] mid;
   logic [CW:0] lo_hi_sum;
   logic [COORD_WIDTH-1:0] ts, te;
   logic [TAG_WIDTH-1:0]   tt;
   logic go_left, go_right;
   logic [1:0] rel;
   logic keep;
   logic [COORD_WIDTH-1:0] rs, re;
   logic wr_en;
   logic in_range;

   function automatic logic [CW-1:0] lo_hi_sum_next(input logic [CW:0] a, input logic [CW:0] b);
      logic [CW:0] s;
      s = a + b;
      return s[CW:1];
   endfunction

   assign ts = rd_ff[MW-1 -: COORD_WIDTH];
   assign te = rd_ff[TAG_WIDTH +: COORD_WIDTH];
   assign tt = rd_ff[TAG_WIDTH-1:0];

   assign lo_hi_sum = lo_ff + hi_ff;
   assign mid = {1'b0, lo_hi_sum[CW:1]};

   assign wr_en = (ctl.op == OP_LATCH) && (req_command == CMD_LOAD) && (count_ff < DEPTH_C);

   always_ff @(posedge clock) begin
      if (wr_en) mem[count_ff[AW-1:0]] <= {req_interval_start, req_interval_stop, req_entry_tag};
      if (ctl.op == OP_READ) rd_ff <= mem[idx_ff[AW-1:0]];
   end

   // classify the entry read against the query
   always_comb begin
      go_left = (qe_ff <= ts);
      go_right = !go_left && (qs_ff >= te);
      if (ts >= qs_ff && te <= qe_ff) rel = REL_IN;
      else if (ts >= qs_ff) rel = REL_RIGHT;
      else if (te <= qe_ff) rel = REL_LEFT;
      else rel = REL_COVER;
      case (rel)
         REL_LEFT:  begin keep = !csr_contain && !csr_cover; rs = qs_ff; re = te; end
         REL_IN:    begin keep = !csr_cover; rs = ts; re = te; end
         REL_RIGHT: begin keep = !csr_contain && !csr_cover; rs = ts; re = qe_ff; end
         default:   begin keep = !csr_contain; rs = qs_ff; re = qe_ff; end
      endcase
      if (!csr_clip) begin
         keep = 1'b1; rs = ts; re = te;
      end
   end

   // range check for walk index (signed, may go to -1 or to count)
   assign in_range = !idx_ff[CW] && (idx_ff[CW-1:0] < count_ff);

   always_comb begin
      count_in = count_ff; lowb_in = lowb_ff;
      lo_in = lo_ff; hi_in = hi_ff; idx_in = idx_ff; hit_in = hit_ff;
      sent_in = sent_ff;
      sts = '0;
      unique case (ctl.op)
         OP_LATCH: begin
            sent_in = 1'b0;
            if (req_command == CMD_CLEAR) begin
               count_in = '0; lowb_in = '0;
            end else if (wr_en) begin
               count_in = count_ff + 1'b1;
            end
            lo_in = {1'b0, lowb_ff};
            hi_in = {1'b0, count_ff} - 1'b1;
            // no entry at or above the low bound: nothing to probe
            if ((req_command == CMD_QUERY) && (lowb_ff >= count_ff)) sts.search_done = 1'b1;
         end
         OP_READ: ;
         OP_SEARCH: begin
            if (go_left) hi_in = mid - 1'b1;
            else if (go_right) lo_in = mid + 1'b1;
            else begin
               hit_in = mid;
               idx_in = mid - 1'b1;
               sts.hit = 1'b1;
               sts.search_done = 1'b1;
               lowb_in = lo_ff[CW-1:0];
               if (keep) sent_in = 1'b1;
            end
            if (!sts.hit) begin
               // next range empty: signed lo_in > hi_in
               if ($signed(lo_in) > $signed(hi_in)) begin
                  sts.search_done = 1'b1;
                  lowb_in = lo_in[CW-1:0];
               end
               idx_in = {1'b0, lo_hi_sum_next(lo_in, hi_in)};
            end
         end
         OP_LWALK, OP_RWALK: begin
            if (!in_range || go_left || go_right) begin
               sts.walk_stop = 1'b1;
               if (ctl.op == OP_LWALK) idx_in = hit_ff + 1'b1;
            end else begin
               if (keep) sent_in = 1'b1;
               idx_in = (ctl.op == OP_LWALK) ? idx_ff - 1'b1 : idx_ff + 1'b1;
            end
         end
         default: ;
      endcase
      // after latching a query the first probe index
      if (ctl.op == OP_LATCH) idx_in = {1'b0, lo_hi_sum_next(lo_in, hi_in)};
      sts.any_sent = sent_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0; lowb_ff <= '0; sent_ff <= 1'b0;
      end else begin
         count_ff <= count_in; lowb_ff <= lowb_in; sent_ff <= sent_in;
      end
      lo_ff <= lo_in; hi_ff <= hi_in; idx_ff <= idx_in; hit_ff <= hit_in;
      if (ctl.op == OP_LATCH) begin
         qs_ff <= req_interval_start; qe_ff <= req_interval_stop;
      end
   end

   // response staging: one held match, emitted when next match or end is known
   logic         pend_ff, pend_in;
   logic [MW+IDX_WIDTH+1:0] pd_ff, pd_in;
   logic         ov_ff, ov_in;
   logic [1:0]   os_ff, os_in;
   logic [IDX_WIDTH-1:0] oi_ff, oi_in;
   logic [COORD_WIDTH-1:0] ors_ff, ors_in, ore_ff, ore_in;
   logic [1:0]   orl_ff, orl_in;
   logic [TAG_WIDTH-1:0] ot_ff, ot_in;
   logic         ol_ff, ol_in;
   logic         new_match;
   logic         final_pt;
   logic [IDX_WIDTH-1:0] cur_idx;

   function automatic logic [1:0] cmd_or_req();
      return (ctl.op == OP_LATCH) ? req_command : CMD_QUERY;
   endfunction

   assign cur_idx = (ctl.op == OP_SEARCH) ? IDX_WIDTH'(mid) : IDX_WIDTH'(idx_ff);
   assign new_match = keep && (((ctl.op == OP_SEARCH) && sts.hit) ||
      (((ctl.op == OP_LWALK) || (ctl.op == OP_RWALK)) && !sts.walk_stop));
   assign final_pt = ((ctl.op == OP_RWALK) && sts.walk_stop) ||
      ((ctl.op == OP_SEARCH) && sts.search_done && !sts.hit);

   always_comb begin
      pend_in = pend_ff; pd_in = pd_ff;
      ov_in = 1'b0; os_in = '0; oi_in = '0; ors_in = '0; ore_in = '0;
      orl_in = '0; ot_in = '0; ol_in = 1'b0;
      if (ctl.emit_simple) begin
         ov_in = 1'b1; ol_in = 1'b1;
         if (cmd_or_req() == CMD_CLEAR) os_in = ST_ACCEPT;
         else if (cmd_or_req() == CMD_LOAD) begin
            if (count_ff < DEPTH_C) begin
               os_in = ST_ACCEPT; oi_in = IDX_WIDTH'(count_ff);
            end else os_in = ST_FULL;
         end else os_in = ST_NONE;
      end else if (pend_ff && (new_match || final_pt)) begin
         ov_in = 1'b1; os_in = ST_MATCH;
         {oi_in, orl_in, ors_in, ore_in, ot_in} = pd_ff;
         ol_in = final_pt && !new_match;
      end
      if (new_match) begin
         pend_in = 1'b1;
         pd_in = {cur_idx, rel, rs, re, tt};
      end else if (final_pt) pend_in = 1'b0;
      if (ctl.op == OP_LATCH) pend_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0; pend_ff <= 1'b0;
      end else begin
         ov_ff <= ov_in; pend_ff <= pend_in;
      end
      pd_ff <= pd_in;
      os_ff <= os_in; oi_ff <= oi_in; ors_ff <= ors_in; ore_ff <= ore_in;
      orl_ff <= orl_in; ot_ff <= ot_in; ol_ff <= ol_in;
   end

   assign rsp_valid = ov_ff;
   assign rsp_status = os_ff;
   assign rsp_entry_index = oi_ff;
   assign rsp_result_start = ors_ff;
   assign rsp_result_stop = ore_ff;
   assign rsp_relation = orl_ff;
   assign rsp_result_tag = ot_ff;
   assign rsp_last = ol_ff;
endmodule

>>> test/tb_top.sv
// Self-checking testbench for interval_overlap_intersect_core.
// Depends on ioi_pkg; predicts table loads and overlap queries and checks every response.
`timescale 1ns / 1ps

typedef struct packed {
   logic [1:0]  status;
   logic [5:0]  index;
   logic [30:0] rstart;
   logic [30:0] rstop;
   logic [1:0]  relation;
   logic [15:0] tag;
   logic        last;
} rsp_type;

class overlap_scoreboard;
   localparam int DEPTH = 64;
   localparam int GO_LEFT = 4;
   localparam int GO_RIGHT = 5;

   logic [30:0] tbl_start [DEPTH];
   logic [30:0] tbl_stop [DEPTH];
   logic [15:0] tbl_tag [DEPTH];
   int count;
   int low_bound;
   bit clip, contained, covering;
   rsp_type pending[$];
   int mismatches;

   function new();
      count = 0;
      low_bound = 0;
      clip = 0;
      contained = 0;
      covering = 0;
      mismatches = 0;
   endfunction

   function void set_csr(logic [1:0] idx, bit val);
      if (idx == ioi_pkg::CSR_CLIP) clip = val;
      else if (idx == ioi_pkg::CSR_CONTAIN) contained = val;
      else if (idx == ioi_pkg::CSR_COVER) covering = val;
   endfunction

   function int classify(logic [30:0] ts, logic [30:0] te, logic [30:0] qs, logic [30:0] qe);
      if (qe <= ts) return GO_LEFT;
      if (qs >= te) return GO_RIGHT;
      if (ts >= qs && te <= qe) return ioi_pkg::REL_IN;
      if (ts >= qs) return ioi_pkg::REL_RIGHT;
      if (te <= qe) return ioi_pkg::REL_LEFT;
      return ioi_pkg::REL_COVER;
   endfunction

   function void push(logic [1:0] st, int idx, logic [30:0] rs, logic [30:0] re,
                      int rel, logic [15:0] tag);
      rsp_type r;
      r.status = st;
      r.index = idx[5:0];
      r.rstart = rs;
      r.rstop = re;
      r.relation = rel[1:0];
      r.tag = tag;
      r.last = 0;
      pending.insert(pending.size(), r);
   endfunction

   function int emit_match(int i, int rel, logic [30:0] qs, logic [30:0] qe);
      logic [30:0] rs, re;
      bit keep;
      rs = tbl_start[i];
      re = tbl_stop[i];
      keep = 1;
      if (clip) begin
         case (rel)
            ioi_pkg::REL_LEFT: begin
               keep = !contained && !covering;
               rs = qs;
            end
            ioi_pkg::REL_IN: keep = !covering;
            ioi_pkg::REL_RIGHT: begin
               keep = !contained && !covering;
               re = qe;
            end
            default: begin
               keep = !contained;
               rs = qs;
               re = qe;
            end
         endcase
      end
      if (!keep) return 0;
      push(ioi_pkg::ST_MATCH, i, rs, re, rel, tbl_tag[i]);
      return 1;
   endfunction

   // note one accepted request and queue its expected responses
   function void note_request(logic [1:0] cmd, logic [30:0] qs, logic [30:0] qe,
                              logic [15:0] tag);
      int lo, hi, mid, hit, c, r, n, i;
      if (cmd == ioi_pkg::CMD_CLEAR) begin
         count = 0;
         low_bound = 0;
         push(ioi_pkg::ST_ACCEPT, 0, 0, 0, 0, 0);
      end else if (cmd == ioi_pkg::CMD_LOAD) begin
         if (count >= DEPTH) push(ioi_pkg::ST_FULL, 0, 0, 0, 0, 0);
         else begin
            tbl_start[count] = qs;
            tbl_stop[count] = qe;
            tbl_tag[count] = tag;
            push(ioi_pkg::ST_ACCEPT, count, 0, 0, 0, 0);
            count++;
         end
      end else if (cmd == ioi_pkg::CMD_QUERY) begin
         lo = low_bound;
         hi = count - 1;
         hit = -1;
         c = 0;
         n = 0;
         while (lo <= hi) begin
            mid = (lo + hi) / 2;
            c = classify(tbl_start[mid], tbl_stop[mid], qs, qe);
            if (c == GO_LEFT) hi = mid - 1;
            else if (c == GO_RIGHT) lo = mid + 1;
            else begin
               hit = mid;
               break;
            end
         end
         low_bound = lo;
         if (hit >= 0) begin
            n += emit_match(hit, c, qs, qe);
            for (i = hit - 1; i >= 0; i--) begin
               r = classify(tbl_start[i], tbl_stop[i], qs, qe);
               if (r >= GO_LEFT) break;
               n += emit_match(i, r, qs, qe);
            end
            for (i = hit + 1; i < count; i++) begin
               r = classify(tbl_start[i], tbl_stop[i], qs, qe);
               if (r >= GO_LEFT) break;
               n += emit_match(i, r, qs, qe);
            end
         end
         if (n == 0) push(ioi_pkg::ST_NONE, 0, 0, 0, 0, 0);
      end else return;
      pending[pending.size()-1].last = 1;
   endfunction

   // compare one strobed response with the oldest expectation
   function void check_response(rsp_type got);
      rsp_type want;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected response %p", got);
         return;
      end
      want = pending.pop_front();
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
      end
   endfunction
endclass

module tb_top;
   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic [1:0] req_command = 0;
   logic [30:0] req_interval_start = 0;
   logic [30:0] req_interval_stop = 0;
   logic [15:0] req_entry_tag = 0;
   logic rsp_valid;
   logic [1:0] rsp_status;
   logic [5:0] rsp_entry_index;
   logic [30:0] rsp_result_start;
   logic [30:0] rsp_result_stop;
   logic [1:0] rsp_relation;
   logic [15:0] rsp_result_tag;
   logic rsp_last;
   logic csr_valid = 0;
   logic csr_ready;
   logic [1:0] csr_index = 0;
   logic csr_data = 0;

   overlap_scoreboard sb = new();
   bit calm = 0;

   interval_overlap_intersect_core u_top (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("TEST FAILED");
      $finish;
   end

   // sample responses
   always @(posedge clock) begin
      rsp_type r;
      if (!reset && rsp_valid) begin
         r = {rsp_status, rsp_entry_index, rsp_result_start, rsp_result_stop,
              rsp_relation, rsp_result_tag, rsp_last};
         sb.check_response(r);
      end
   end

   // start stays high between back-to-back requests; a gap drops it
   task automatic idle_gap();
      if (!calm && $urandom_range(0, 3) == 0) begin
         start <= 0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   // present one request and hold it until accepted
   task automatic send(logic [1:0] cmd, logic [30:0] s, logic [30:0] e, logic [15:0] tag);
      idle_gap();
      start <= 1;
      req_command <= cmd;
      req_interval_start <= s;
      req_interval_stop <= e;
      req_entry_tag <= tag;
      do @(posedge clock); while (busy);
      sb.note_request(cmd, s, e, tag);
   endtask

   task automatic drain();
      start <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, bit val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      sb.set_csr(idx, val);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   task automatic set_mode(bit c, bit ct, bit cv);
      drain();
      write_csr(ioi_pkg::CSR_CLIP, c);
      write_csr(ioi_pkg::CSR_CONTAIN, ct);
      write_csr(ioi_pkg::CSR_COVER, cv);
   endtask

   // sorted table of random intervals, then ascending queries with an occasional random start
   task automatic sorted_batch(int n, int nq, int span);
      logic [30:0] base, s, qs;
      base = 31'($urandom_range(0, 1000));
      send(ioi_pkg::CMD_CLEAR, 31'($urandom), 31'($urandom), 16'($urandom));
      for (int i = 0; i < n; i++) begin
         base = base + 31'($urandom_range(0, span));
         send(ioi_pkg::CMD_LOAD, base, base + 31'($urandom_range(1, 3 * span)),
              16'($urandom));
      end
      qs = 0;
      for (int i = 0; i < nq; i++) begin
         qs = qs + 31'($urandom_range(0, 2 * span));
         s = ($urandom_range(0, 9) == 0) ? 31'($urandom) : qs;
         send(ioi_pkg::CMD_QUERY, s, s + 31'($urandom_range(0, 3 * span)), 16'($urandom));
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes, every command, full table, no match, unknown command
      send(ioi_pkg::CMD_QUERY, 0, 31'h7fffffff, 16'hffff);
      send(ioi_pkg::CMD_LOAD, 0, 31'h7fffffff, 16'hffff);
      send(ioi_pkg::CMD_LOAD, 31'h7ffffffe, 31'h7fffffff, 16'h0000);
      send(ioi_pkg::CMD_LOAD, 100, 50, 16'h5555);
      send(ioi_pkg::CMD_QUERY, 0, 31'h7fffffff, 0);
      send(ioi_pkg::CMD_QUERY, 10, 10, 0);
      send(2'd3, 31'h7fffffff, 31'h7fffffff, 16'hffff);
      send(ioi_pkg::CMD_CLEAR, 31'h7fffffff, 0, 16'haaaa);
      for (int i = 0; i < 65; i++) send(ioi_pkg::CMD_LOAD, 31'(i * 10), 31'(i * 10 + 25), 16'(i));
      send(ioi_pkg::CMD_QUERY, 0, 31'h7fffffff, 0);
      send(ioi_pkg::CMD_QUERY, 700, 800, 0);

      // clip mode settings, extremes included
      for (int m = 0; m < 5; m++) begin
         case (m)
            0: set_mode(1, 0, 0);
            1: set_mode(1, 1, 0);
            2: set_mode(1, 0, 1);
            3: set_mode(1, 1, 1);
            default: set_mode(0, 1, 1);
         endcase
         sorted_batch(6, 5, 40);
         sorted_batch($urandom_range(1, 10), $urandom_range(3, 8), $urandom_range(5, 100));
         repeat ($urandom_range(6, 12)) begin
            send(2'($urandom_range(0, 3)), 31'($urandom), 31'($urandom), 16'($urandom));
         end
      end

      // final part with no idling
      set_mode(1, 0, 0);
      calm = 1;
      sorted_batch(10, 10, 30);

      drain();
      if (sb.mismatches == 0 && sb.pending.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
